/* rtl/core/cpp_token_boundary_marker_unit_assert.svh */
// Assertion macros for the token boundary marker.
`ifndef CPP_TOKEN_BOUNDARY_MARKER_UNIT_ASSERT_SVH
`define CPP_TOKEN_BOUNDARY_MARKER_UNIT_ASSERT_SVH
// same-cycle implication, checked outside reset
`define CTBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define CTBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/ctbm_pkg.sv */
// Package: lexer modes, result types and the per-character lexer step.
`timescale 1ns / 1ps
package ctbm_pkg;

    localparam logic [3:0] M_BETWEEN   = 4'd0;
    localparam logic [3:0] M_INL_OPEN  = 4'd1;
    localparam logic [3:0] M_INLINE    = 4'd2;
    localparam logic [3:0] M_BLK_BODY  = 4'd3;
    localparam logic [3:0] M_BLK_STAR  = 4'd4;
    localparam logic [3:0] M_NUM_DEC   = 4'd5;
    localparam logic [3:0] M_NUM_EXP   = 4'd6;
    localparam logic [3:0] M_NUM_HEX   = 4'd7;
    localparam logic [3:0] M_INC_WORD  = 4'd8;
    localparam logic [3:0] M_INC_DOT   = 4'd9;
    localparam logic [3:0] M_INC_QUOTE = 4'd10;
    localparam logic [3:0] M_STR       = 4'd11;
    localparam logic [3:0] M_STR_ESC   = 4'd12;
    localparam logic [3:0] M_OP        = 4'd13;
    localparam logic [3:0] M_WORD      = 4'd14;

    localparam logic [15:0] P_LINE_CMT  = 16'h2F2F;
    localparam logic [15:0] P_BLK_OPEN  = 16'h2A2F;
    localparam logic [15:0] P_HASH      = 16'h0023;
    localparam logic [15:0] P_SLASH     = 16'h002F;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef struct packed {
        logic [3:0]  mode;
        logic        blk;
        logic [15:0] prefix;
        logic        incl;
    } t_lex;

    typedef struct packed {
        logic [7:0] out_char;
        logic       starts_token;
        logic       skipped;
        logic       last_of_line;
    } t_res;

    // results of one accepted beat: zero, one or two
    typedef struct packed {
        logic       push0;
        logic       push1;
        t_res       res0;
        t_res       res1;
    } t_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {" ", "\t"};
    endfunction

    function automatic logic is_grp_a(input logic [7:0] c);
        return c inside {"|", "&", "+", ">", "<", ":", "="};
    endfunction

    function automatic logic is_grp_b(input logic [7:0] c);
        return c inside {"*", "%", "!", "~", ",", ";", "^", "?", "#"};
    endfunction

    function automatic logic word_stop(input logic [7:0] c);
        return c inside {"+", "-", "*", "/", "(", "{", ".", "&", ")", "}", ",", "|",
                         "[", "<", ";", "!", "]", ">", ":", "^", "#", "~", "\"",
                         "'", "=", "%", " ", "\t", "?"};
    endfunction

    function automatic logic inc_stop(input logic [7:0] c);
        return c inside {" ", "\t", "<", "\""};
    endfunction

    function automatic t_lex end_token(input t_lex s);
        t_lex r;
        r = s;
        if (s.mode == M_OP || s.mode == M_INC_WORD) begin
            r.prefix = '0;
            r.mode   = M_BETWEEN;
            if (s.prefix == P_LINE_CMT) begin
                r.mode = M_INL_OPEN;
            end else if (s.prefix == P_BLK_OPEN) begin
                r.blk = 1'b1;
            end else if (s.prefix == P_HASH) begin
                r.incl = 1'b1;
            end
        end else if (s.mode != M_INL_OPEN) begin
            r.mode   = M_BETWEEN;
            r.prefix = '0;
        end
        return r;
    endfunction

    // operator continuation; took reports whether c joins the operator
    function automatic t_lex op_cont(input t_lex s, input logic [7:0] c, output logic took);
        t_lex r;
        logic [7:0] p1;
        logic [7:0] p2;
        r    = s;
        took = 1'b0;
        p1   = s.prefix[7:0];
        p2   = s.prefix[15:8];
        if (p1 == "/") begin
            if (c inside {"/", "*", "="}) begin
                r.prefix = {c, p1};
                r = end_token(r);
                took = 1'b1;
            end
        end else if (p1 == ".") begin
            if (c == "*") begin
                r.mode = M_BETWEEN; r.prefix = '0; took = 1'b1;
            end else if (is_digit(c)) begin
                r.mode = M_NUM_DEC; r.prefix = '0; took = 1'b1;
            end
        end else if (p1 == "-") begin
            if (p2 == 8'd0) begin
                if (c == "-" || c == "=") begin
                    r.mode = M_BETWEEN; r.prefix = '0; took = 1'b1;
                end else if (c == ">") begin
                    r.prefix = {c, p1}; took = 1'b1;
                end
            end else if (c == "*") begin
                r.mode = M_BETWEEN; r.prefix = '0; took = 1'b1;
            end
        end else if (p2 == 8'd0) begin
            took = is_grp_a(p1) ? (c == p1 || c == "=") : (c == "=" || c == ":");
            if (took) begin
                r.prefix = {c, p1};
            end
        end else if (c == "=") begin
            r.mode = M_BETWEEN; r.prefix = '0; took = 1'b1;
        end
        return r;
    endfunction

    function automatic t_lex start_token(input t_lex s, input logic [7:0] c, input logic hn,
                                         input logic [7:0] nx, output logic st,
                                         output logic sk);
        t_lex r;
        r = s;
        st = 1'b1;
        sk = 1'b0;
        r.prefix = '0;
        if (s.mode == M_INL_OPEN) begin
            r.mode = M_INLINE;
        end else if (s.blk) begin
            if (c == "*" && hn && nx == "/") begin
                r.mode = M_BLK_STAR;
            end else if (c == "*" && hn) begin
                r.mode = M_OP; r.prefix = {8'd0, c};
            end else begin
                r.mode = M_BLK_BODY;
            end
        end else if (is_ws(c)) begin
            st = 1'b0; sk = 1'b1; r.mode = M_BETWEEN;
        end else if (is_digit(c)) begin
            r.mode = M_NUM_DEC;
        end else if (s.incl) begin
            if (c == ".") begin
                r.mode = M_INC_DOT;
            end else if (c == "<" || c == "\"") begin
                r.mode = M_INC_QUOTE;
            end else begin
                r.mode = M_INC_WORD;
                r.prefix = (c == "/" || c == "#") ? {8'd0, c} : 16'd0;
            end
        end else if (c == "\"" || c == "'") begin
            r.mode = M_STR; r.prefix = {8'd0, c};
        end else if (is_grp_a(c) || is_grp_b(c) || c == "." || c == "-" || c == "/") begin
            r.mode = M_OP; r.prefix = {8'd0, c};
        end else if (c inside {"(", ")", "[", "]", "{", "}"}) begin
            r.mode = M_BETWEEN;
        end else begin
            r.mode = M_WORD;
        end
        return r;
    endfunction

    // classify one character given one character of lookahead (hn = lookahead present)
    function automatic t_lex lex_char(input t_lex s, input logic [7:0] c, input logic hn,
                                      input logic [7:0] nx, output logic st, output logic sk);
        t_lex r;
        logic took;
        r    = s;
        took = 1'b0;
        st   = 1'b0;
        sk   = 1'b0;
        case (s.mode)
            M_INLINE:   took = 1'b1;
            M_BLK_BODY: took = !(c == "*" && hn && nx == "/");
            M_BLK_STAR: begin
                if (c == "/") begin
                    took = 1'b1; r.blk = 1'b0; r.mode = M_BETWEEN;
                end
            end
            M_NUM_DEC, M_NUM_EXP: begin
                if (s.mode == M_NUM_EXP && (c == "+" || c == "-")) begin
                    took = 1'b1; r.mode = M_NUM_DEC;
                end else if (is_digit(c) || c inside {"e", ".", "f", "F", "l", "L", "U", "E"})
                begin
                    took = 1'b1;
                    r.mode = (c == "e" || c == "E") ? M_NUM_EXP : M_NUM_DEC;
                end else if (c == "x") begin
                    took = 1'b1; r.mode = M_NUM_HEX;
                end
            end
            M_NUM_HEX: took = is_digit(c) || c inside {"A", "B", "C", "D", "E", "F",
                                                        "L", "l", "U"};
            M_INC_DOT: begin
                if (is_digit(c)) begin
                    took = 1'b1; r.mode = M_NUM_DEC;
                end else if (!inc_stop(c)) begin
                    took = 1'b1; r.mode = M_INC_WORD; r.prefix = '0;
                end
            end
            M_INC_WORD: begin
                if (!inc_stop(c)) begin
                    took = 1'b1;
                    if (s.prefix == P_SLASH && (c == "/" || c == "*")) begin
                        r.prefix = {c, 8'h2F};
                    end else begin
                        r.prefix = '0;
                    end
                end
            end
            M_INC_QUOTE: begin
                took = 1'b1;
                if (c == ">" || c == "\"") begin
                    r.mode = M_BETWEEN;
                end
            end
            M_STR: begin
                took = 1'b1;
                if (c == s.prefix[7:0]) begin
                    r.mode = M_BETWEEN; r.prefix = '0;
                end else if (c == "\\") begin
                    r.mode = M_STR_ESC;
                end
            end
            M_STR_ESC: begin
                took = 1'b1; r.mode = M_STR;
            end
            M_OP:       r = op_cont(s, c, took);
            M_WORD:     took = !word_stop(c);
            M_INL_OPEN: took = 1'b0;
            default:    r.mode = M_BETWEEN;
        endcase
        if (!took) begin
            r = end_token(r);
            r = start_token(r, c, hn, nx, st, sk);
        end
        return r;
    endfunction

endpackage

/* rtl/core/ctbm_if.sv */
// Stream interfaces: source characters in, classified characters out.
`timescale 1ns / 1ps
interface ctbm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       line_end;
    modport source (output valid, output in_char, output line_end, input ready);
    modport sink (input valid, input in_char, input line_end, output ready);
endinterface

interface ctbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       starts_token;
    logic       skipped;
    logic       last_of_line;
    modport source (output valid, output out_char, output starts_token, output skipped,
                    output last_of_line, input ready);
    modport sink (input valid, input out_char, input starts_token, input skipped,
                  input last_of_line, output ready);
endinterface

/* rtl/core/ctbm_lex.sv */
// Lexer state and one-character lookahead; produces up to two results per beat.
`timescale 1ns / 1ps
module ctbm_lex (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_char,
    input  logic                 i_line_end,
    output ctbm_pkg::t_push      o_push,
    output logic                 o_held_valid
);
    ctbm_pkg::t_lex r_lex, n_lex;
    logic [7:0] r_held, n_held;
    logic       r_held_valid, n_held_valid;
    ctbm_pkg::t_lex s_mid, s_end;
    logic       st0, sk0, st1, sk1;

    always_comb begin
        ctbm_pkg::t_lex a;
        a = r_lex;
        st0 = 1'b0;
        sk0 = 1'b0;
        st1 = 1'b0;
        sk1 = 1'b0;
        // held character sees the new one as lookahead
        if (r_held_valid) begin
            a = ctbm_pkg::lex_char(r_lex, r_held, 1'b1, i_char, st0, sk0);
        end
        s_mid = a;
        s_end = ctbm_pkg::lex_char(a, i_char, 1'b0, 8'd0, st1, sk1);
        s_end = ctbm_pkg::end_token(s_end);
        s_end.mode   = ctbm_pkg::M_BETWEEN;
        s_end.prefix = '0;
        s_end.incl   = 1'b0;

        n_lex        = r_lex;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        if (i_accept) begin
            if (i_line_end) begin
                n_lex        = s_end;
                n_held       = 8'd0;
                n_held_valid = 1'b0;
            end else begin
                n_lex        = s_mid;
                n_held       = i_char;
                n_held_valid = 1'b1;
            end
        end

        o_push.push0 = i_accept && r_held_valid;
        o_push.res0  = '{out_char: r_held, starts_token: st0, skipped: sk0,
                         last_of_line: 1'b0};
        o_push.push1 = i_accept && i_line_end;
        o_push.res1  = '{out_char: i_char, starts_token: st1, skipped: sk1,
                         last_of_line: 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex        <= '{mode: ctbm_pkg::M_BETWEEN, blk: 1'b0, prefix: 16'd0,
                              incl: 1'b0};
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
        end else begin
            r_lex        <= n_lex;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

    assign o_held_valid = r_held_valid;
endmodule

/* rtl/core/ctbm_outq.sv */
// Four-entry result queue: takes up to two results a cycle, sends one.
`timescale 1ns / 1ps
module ctbm_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ctbm_pkg::t_push            i_push,
    output logic                       o_room,
    output logic                       o_valid,
    output ctbm_pkg::t_res             o_res,
    input  logic                       i_ready,
    output logic [ctbm_pkg::QAw:0]     o_count
);
    ctbm_pkg::t_res r_mem [ctbm_pkg::QDepth];
    logic [ctbm_pkg::QAw-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [ctbm_pkg::QAw:0]   r_cnt, n_cnt;
    logic                     pop;
    logic [ctbm_pkg::QAw-1:0] wr_a, wr_b;
    logic [ctbm_pkg::QAw:0]   n_push;

    assign pop     = (r_cnt != '0) && i_ready;
    assign n_push  = {{ctbm_pkg::QAw{1'b0}}, i_push.push0} +
                     {{ctbm_pkg::QAw{1'b0}}, i_push.push1};
    assign wr_a    = r_wr;
    assign wr_b    = r_wr + {{(ctbm_pkg::QAw-1){1'b0}}, i_push.push0};
    assign n_wr    = r_wr + n_push[ctbm_pkg::QAw-1:0];
    assign n_rd    = r_rd + {{(ctbm_pkg::QAw-1){1'b0}}, pop};
    assign n_cnt   = r_cnt + n_push - {{ctbm_pkg::QAw{1'b0}}, pop};

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[wr_a] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_b] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // room for a full two-result beat
    assign o_room  = r_cnt <= (ctbm_pkg::QAw + 1)'(ctbm_pkg::QDepth - 2);
    assign o_valid = r_cnt != '0;
    assign o_res   = r_mem[r_rd];
    assign o_count = r_cnt;
endmodule

/* rtl/core/cpp_token_boundary_marker_unit.sv */
// C++ token boundary marker: per-character lexer with a small result queue.
// Usage:
//   i_in carries one source character per beat (in_char) with line_end set on the
//   last character of each line. o_out returns every character once, tagged with
//   starts_token, skipped (whitespace between tokens) and last_of_line.
//   A character is held until the next one arrives, for one character of lookahead;
//   a line_end beat flushes the held character and itself, yielding two results
//   (one on a one-character line); other beats yield one, none on a line's first.
// Results are registered in the queue and leave on o_out in order of release.
// Throughput: one input beat per cycle, bounded by the one-result-per-cycle output;
//   the four-entry queue absorbs the extra result of line-end beats, and i_in.ready
//   drops while fewer than two entries are free.
// Reset (synchronous, active low): lexer back between tokens, no held character,
//   queue empty. A stalled receiver fills the queue and then holds off i_in.
`timescale 1ns / 1ps
`include "cpp_token_boundary_marker_unit_assert.svh"
module cpp_token_boundary_marker_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ctbm_in_if.sink         i_in,
    ctbm_out_if.source      o_out
);
    ctbm_pkg::t_push          push;
    ctbm_pkg::t_res           res;
    logic                     room;
    logic                     accept;
    logic                     held_valid;
    logic [ctbm_pkg::QAw:0]   count;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    ctbm_lex u_lex (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char       (i_in.in_char),
        .i_line_end   (i_in.line_end),
        .o_push       (push),
        .o_held_valid (held_valid)
    );

    ctbm_outq u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_res   (res),
        .i_ready (o_out.ready),
        .o_count (count)
    );

    assign o_out.out_char     = res.out_char;
    assign o_out.starts_token = res.starts_token;
    assign o_out.skipped      = res.skipped;
    assign o_out.last_of_line = res.last_of_line;

    `CTBM_ASSERT_NXT(a_line_end_flush, i_clk, i_rst_n, accept && i_in.line_end,
        o_out.valid && !held_valid, "line end beat left a held character or no result")
    `CTBM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        count <= (ctbm_pkg::QAw + 1)'(ctbm_pkg::QDepth), "result queue overflow")
    `CTBM_ASSERT_IMP(a_stall_has_data, i_clk, i_rst_n, !i_in.ready, o_out.valid,
        "input stalled with an empty result queue")
    `CTBM_ASSERT_NXT(a_mid_line_holds, i_clk, i_rst_n, accept && !i_in.line_end,
        held_valid, "mid-line beat not held for lookahead")
endmodule

/* dv/ctbm_test_if.sv */
// Testbench package: source beat type shared by the stimulus code.
`timescale 1ns / 1ps
package ctbm_test_pkg;
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_src_beat;
endpackage

/* dv/cpp_token_boundary_marker_unit_test.sv */
// Self-checking testbench for the C++ token boundary marker: directed and random source lines, predicted tags.
`timescale 1ns / 1ps
module cpp_token_boundary_marker_unit_test;

    localparam logic [3:0] L_BETWEEN   = 4'd0;
    localparam logic [3:0] L_INL_OPEN  = 4'd1;
    localparam logic [3:0] L_INLINE    = 4'd2;
    localparam logic [3:0] L_BLK_BODY  = 4'd3;
    localparam logic [3:0] L_BLK_STAR  = 4'd4;
    localparam logic [3:0] L_NUM_DEC   = 4'd5;
    localparam logic [3:0] L_NUM_EXP   = 4'd6;
    localparam logic [3:0] L_NUM_HEX   = 4'd7;
    localparam logic [3:0] L_INC_WORD  = 4'd8;
    localparam logic [3:0] L_INC_DOT   = 4'd9;
    localparam logic [3:0] L_INC_QUOTE = 4'd10;
    localparam logic [3:0] L_STR       = 4'd11;
    localparam logic [3:0] L_STR_ESC   = 4'd12;
    localparam logic [3:0] L_OP        = 4'd13;
    localparam logic [3:0] L_WORD      = 4'd14;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    ctbm_in_if  src ();
    ctbm_out_if res ();

    cpp_token_boundary_marker_unit dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(src),
                                        .o_out(res));

    always #4 i_clk = ~i_clk;

    ctbm_test_pkg::t_src_beat pending_chars[$];
    ctbm_pkg::t_res           tagged_chars[$];
    int        mismatches = 0;
    bit        stim_done = 1'b0;
    bit        quiet_tail = 1'b0;
    bit        hold_sender = 1'b0;
    bit        hold_receiver = 1'b0;

    // lexer copy
    logic [3:0]  lx_mode;
    logic        lx_blk;
    logic [15:0] lx_pfx;
    logic        lx_incl;
    logic [7:0]  lx_held;
    logic        lx_hv;

    function automatic bit in_str(logic [7:0] c, string s);
        for (int k = 0; k < s.len(); k++) if (s[k] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit pair_op(logic [7:0] c);
        return in_str(c, "|&+><:=");
    endfunction

    task automatic close_token();
        logic [15:0] p;
        if (lx_mode == L_OP || lx_mode == L_INC_WORD) begin
            p = lx_pfx;
            lx_pfx = '0;
            lx_mode = L_BETWEEN;
            if (p == 16'h2F2F) lx_mode = L_INL_OPEN;
            else if (p == 16'h2A2F) lx_blk = 1'b1;
            else if (p == 16'h0023) lx_incl = 1'b1;
        end else if (lx_mode != L_INL_OPEN) begin
            lx_mode = L_BETWEEN;
            lx_pfx = '0;
        end
    endtask

    task automatic extend_operator(input logic [7:0] c, output bit took);
        logic [7:0] p1, p2;
        p1 = lx_pfx[7:0];
        p2 = lx_pfx[15:8];
        took = 1'b0;
        if (p1 == "/") begin
            if (c == "/" || c == "*" || c == "=") begin
                lx_pfx = {c, p1}; close_token(); took = 1'b1;
            end
        end else if (p1 == ".") begin
            if (c == "*") begin lx_mode = L_BETWEEN; lx_pfx = '0; took = 1'b1; end
            else if (dig(c)) begin lx_mode = L_NUM_DEC; lx_pfx = '0; took = 1'b1; end
        end else if (p1 == "-") begin
            if (p2 == 0) begin
                if (c == "-" || c == "=") begin
                    lx_mode = L_BETWEEN; lx_pfx = '0; took = 1'b1;
                end else if (c == ">") begin
                    lx_pfx = {c, p1}; took = 1'b1;
                end
            end else if (c == "*") begin
                lx_mode = L_BETWEEN; lx_pfx = '0; took = 1'b1;
            end
        end else if (p2 == 0) begin
            took = pair_op(p1) ? (c == p1 || c == "=") : (c == "=" || c == ":");
            if (took) lx_pfx = {c, p1};
        end else if (c == "=") begin
            lx_mode = L_BETWEEN; lx_pfx = '0; took = 1'b1;
        end
    endtask

    task automatic open_token(input logic [7:0] c, input bit hn, input logic [7:0] nx,
                              output logic st, output logic sk);
        st = 1'b1;
        sk = 1'b0;
        lx_pfx = '0;
        if (lx_mode == L_INL_OPEN) lx_mode = L_INLINE;
        else if (lx_blk) begin
            if (c == "*" && hn && nx == "/") lx_mode = L_BLK_STAR;
            else if (c == "*" && hn) begin lx_mode = L_OP; lx_pfx = {8'd0, c}; end
            else lx_mode = L_BLK_BODY;
        end else if (c == " " || c == "\t") begin
            st = 1'b0; sk = 1'b1; lx_mode = L_BETWEEN;
        end else if (dig(c)) lx_mode = L_NUM_DEC;
        else if (lx_incl) begin
            if (c == ".") lx_mode = L_INC_DOT;
            else if (c == "<" || c == "\"") lx_mode = L_INC_QUOTE;
            else begin
                lx_mode = L_INC_WORD;
                lx_pfx = (c == "/" || c == "#") ? {8'd0, c} : 16'd0;
            end
        end else if (c == "\"" || c == "'") begin
            lx_mode = L_STR; lx_pfx = {8'd0, c};
        end else if (pair_op(c) || in_str(c, "*%!~,;^?#.-/")) begin
            lx_mode = L_OP; lx_pfx = {8'd0, c};
        end else if (in_str(c, "()[]{}")) lx_mode = L_BETWEEN;
        else lx_mode = L_WORD;
    endtask

    task automatic classify(input logic [7:0] c, input bit hn, input logic [7:0] nx,
                            input logic eol);
        bit took;
        logic st, sk;
        ctbm_pkg::t_res r;
        took = 1'b0;
        case (lx_mode)
            L_INLINE:   took = 1'b1;
            L_BLK_BODY: took = !(c == "*" && hn && nx == "/");
            L_BLK_STAR: if (c == "/") begin
                took = 1'b1; lx_blk = 1'b0; lx_mode = L_BETWEEN;
            end
            L_NUM_DEC, L_NUM_EXP: begin
                if (lx_mode == L_NUM_EXP && (c == "+" || c == "-")) begin
                    took = 1'b1; lx_mode = L_NUM_DEC;
                end else if (dig(c) || in_str(c, "e.fFlLUE")) begin
                    took = 1'b1;
                    lx_mode = (c == "e" || c == "E") ? L_NUM_EXP : L_NUM_DEC;
                end else if (c == "x") begin
                    took = 1'b1; lx_mode = L_NUM_HEX;
                end
            end
            L_NUM_HEX: took = dig(c) || in_str(c, "ABCDEFLlU");
            L_INC_DOT: begin
                if (dig(c)) begin took = 1'b1; lx_mode = L_NUM_DEC; end
                else if (!in_str(c, " \t<\"")) begin
                    took = 1'b1; lx_mode = L_INC_WORD; lx_pfx = '0;
                end
            end
            L_INC_WORD: if (!in_str(c, " \t<\"")) begin
                took = 1'b1;
                if (lx_pfx == 16'h002F && (c == "/" || c == "*")) lx_pfx = {c, 8'h2F};
                else lx_pfx = '0;
            end
            L_INC_QUOTE: begin
                took = 1'b1;
                if (c == ">" || c == "\"") lx_mode = L_BETWEEN;
            end
            L_STR: begin
                took = 1'b1;
                if (c == lx_pfx[7:0]) begin lx_mode = L_BETWEEN; lx_pfx = '0; end
                else if (c == "\\") lx_mode = L_STR_ESC;
            end
            L_STR_ESC: begin took = 1'b1; lx_mode = L_STR; end
            L_OP:      extend_operator(c, took);
            L_WORD:    took = !in_str(c, "+-*/({.&)},|[<;!]>:^#~\"'=% \t?");
            L_INL_OPEN: took = 1'b0;
            default:   lx_mode = L_BETWEEN;
        endcase
        st = 1'b0;
        sk = 1'b0;
        if (!took) begin
            close_token();
            open_token(c, hn, nx, st, sk);
        end
        r.out_char = c;
        r.starts_token = st;
        r.skipped = sk;
        r.last_of_line = eol;
        tagged_chars.push_back(r);
    endtask

    task automatic predict_beat(input ctbm_test_pkg::t_src_beat b);
        if (lx_hv) begin
            classify(lx_held, 1'b1, b.ch, 1'b0);
            lx_hv = 1'b0;
        end
        if (!b.eol) begin
            lx_held = b.ch;
            lx_hv = 1'b1;
        end else begin
            classify(b.ch, 1'b0, 8'd0, 1'b1);
            close_token();
            lx_mode = L_BETWEEN;
            lx_pfx = '0;
            lx_incl = 1'b0;
            lx_held = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic add_line(input string s);
        ctbm_test_pkg::t_src_beat b;
        for (int k = 0; k < s.len(); k++) begin
            b.ch = s[k];
            b.eol = (k == s.len() - 1);
            pending_chars.push_back(b);
        end
    endtask

    task automatic add_raw(input logic [7:0] c, input logic eol);
        ctbm_test_pkg::t_src_beat b;
        b.ch = c;
        b.eol = eol;
        pending_chars.push_back(b);
    endtask

    function automatic string random_fragment();
        string frags[24] = '{"int", " ", "\t", "x1", "0x1F", "12.5e-3f", "1E+9L", ".5",
            "->*", "<<=", ">>=", "::", "!=", "/*", "*/", "//", "\"a\\\"b\"", "'\\''",
            "#include <a.h>", "# \"x.h\" .3 .a //q", "{", "(", "*", "a/*b*c*/d"};
        return frags[$urandom_range(0, 23)];
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src.valid <= 1'b0;
        end else begin
            if (src.valid && src.ready) begin
                predict_beat('{src.in_char, src.line_end});
                void'(pending_chars.pop_front());
            end
            if (src_gap > 0) src_gap = src_gap - 1;
            else if (!quiet_tail && $urandom_range(0, 15) == 0) src_gap = $urandom_range(1, 19);
            if (src.valid && !src.ready) begin
                // a beat on offer stays put until it is taken
                src.valid <= 1'b1;
            end else if (!hold_sender && src_gap == 0 && pending_chars.size() > 0) begin
                src.valid <= 1'b1;
                src.in_char <= pending_chars[0].ch;
                src.line_end <= pending_chars[0].eol;
            end else begin
                src.valid <= 1'b0;
            end
        end
    end

    // monitor
    int snk_gap = 0;
    ctbm_pkg::t_res want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (tagged_chars.size() == 0) begin
                    report_mismatch("unexpected beat", res.out_char, 0);
                end else begin
                    want = tagged_chars.pop_front();
                    if (res.out_char !== want.out_char)
                        report_mismatch("out_char", res.out_char, want.out_char);
                    if (res.starts_token !== want.starts_token)
                        report_mismatch("starts_token", res.starts_token, want.starts_token);
                    if (res.skipped !== want.skipped)
                        report_mismatch("skipped", res.skipped, want.skipped);
                    if (res.last_of_line !== want.last_of_line)
                        report_mismatch("last_of_line", res.last_of_line, want.last_of_line);
                end
            end
            if (snk_gap > 0) snk_gap = snk_gap - 1;
            else if (!quiet_tail && $urandom_range(0, 15) == 0) snk_gap = $urandom_range(1, 19);
            res.ready <= !hold_receiver && snk_gap == 0;
        end
    end

    initial begin
        src.valid = 1'b0;
        src.in_char = '0;
        src.line_end = 1'b0;
        res.ready = 1'b0;
        lx_mode = L_BETWEEN; lx_blk = 1'b0; lx_pfx = '0; lx_incl = 1'b0;
        lx_held = '0; lx_hv = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines: extremes, operators, comments, includes, numbers, literals
        add_raw(8'h00, 1'b1);
        add_raw(8'hFF, 1'b0); add_raw(8'h80, 1'b1);
        add_line("a+=b<<=c->*d.*e--f ? g:h;");
        add_line("x = 0x1fUL + 1.5e-3f*.7E+2 - 09;");
        add_line("s=\"a\\\"b\" 'c' \"open");
        add_line("#include <vec.h> \"q.h\" .5 .a //x");
        add_line("i = 3; // 12 tail   ");
        add_line("p /* 42 * x");
        add_line("  more * text */ q/=2;");
        add_line("/**/ *");
        add_line("\t ( [ { } ] ) ~!%^&|,?");
        add_line("<");
        add_line("/");

        // receiver long hold-off while sender keeps offering
        hold_receiver = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_receiver = 1'b0;
        wait (pending_chars.size() == 0 && !src.valid && tagged_chars.size() == 0);

        // sender pause mid-stream until every expected result has come
        for (int n = 0; n < 40; n++) add_line(random_fragment());
        repeat (30) @(posedge i_clk);
        hold_sender = 1'b1;
        wait (!src.valid && tagged_chars.size() == 0);
        repeat (5) @(posedge i_clk);
        hold_sender = 1'b0;
        wait (pending_chars.size() == 0 && !src.valid && tagged_chars.size() == 0);

        for (int n = 0; n < 90; n++) begin
            int parts;
            int nraw;
            string s;
            s = "";
            parts = $urandom_range(1, 4);
            for (int k = 0; k < parts; k++) s = {s, random_fragment()};
            if ($urandom_range(0, 4) == 0) begin
                nraw = $urandom_range(1, 6);
                for (int k = 0; k < nraw; k++) add_raw(8'($urandom_range(0, 255)), 1'b0);
                add_raw(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                add_line(s);
            end
            if (n == 70) begin
                wait (pending_chars.size() < 50);
                quiet_tail = 1'b1;
            end
            if (pending_chars.size() > 200) wait (pending_chars.size() < 100);
        end
        wait (pending_chars.size() == 0 && !src.valid);
        stim_done = 1'b1;
        wait (tagged_chars.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
